FILE: rtl/bse_pkg.sv
// bse_pkg: shared constants, codes and types for the bounded stack engine
// used by bse_ctrl, bse_datapath and bounded_stack_engine
`timescale 1ns / 1ps

package bse_pkg;

    // storage geometry and field widths
    localparam int DEPTH  = 16;
    localparam int AW     = 4;   // entry index width
    localparam int FW     = 5;   // fill count / capacity width
    localparam int DW     = 32;  // word width
    localparam int CMDW   = 3;
    localparam int STW    = 3;

    typedef logic [CMDW-1:0] cmd_code_t;
    typedef logic [STW-1:0]  status_code_t;

    // command codes
    localparam cmd_code_t CMD_PUSH   = 3'd0;
    localparam cmd_code_t CMD_POP    = 3'd1;
    localparam cmd_code_t CMD_PEEK   = 3'd2;
    localparam cmd_code_t CMD_CHANGE = 3'd3;
    localparam cmd_code_t CMD_SEARCH = 3'd4;

    // result status codes
    localparam status_code_t ST_OK       = 3'd0;
    localparam status_code_t ST_FULL     = 3'd1;
    localparam status_code_t ST_EMPTY    = 3'd2;
    localparam status_code_t ST_RANGE    = 3'd3;
    localparam status_code_t ST_NOTFOUND = 3'd4;

    localparam logic [FW-1:0] CAP_RESET = FW'(DEPTH);

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic take_item;
        logic scan_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_needed;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/bse_ctrl.sv
// bse_ctrl: command sequencer for the bounded stack engine
// depends on bse_pkg for the state, command and status types
`timescale 1ns / 1ps

module bse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bse_pkg::dp_stat_t stat,
    output bse_pkg::ctrl_cmd_t cmd
);
    import bse_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.scan_needed ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready      = 1'b0;
        cmd.take_item = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready      = 1'b1;
                cmd.take_item = s_tvalid;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            S_EMIT: begin
                cmd.load_out = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/bse_datapath.sv
// bse_datapath: entry memory, fill level, capacity, search walker and output register
// depends on bse_pkg; driven by bse_ctrl through ctrl_cmd_t
`timescale 1ns / 1ps

module bse_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bse_pkg::ctrl_cmd_t               cmd,
    output bse_pkg::dp_stat_t                stat,
    input  bse_pkg::cmd_code_t               in_cmd,
    input  logic signed [bse_pkg::DW-1:0]    in_value,
    input  logic [bse_pkg::AW-1:0]           in_position,
    input  logic                             cfg_we,
    input  logic [bse_pkg::FW-1:0]           cfg_wdata,
    input  logic                             m_tready,
    output logic                             m_valid,
    output bse_pkg::status_code_t            out_status,
    output logic signed [bse_pkg::DW-1:0]    out_data,
    output logic [bse_pkg::AW-1:0]           out_where,
    output logic [bse_pkg::FW-1:0]           out_fill,
    output logic                             out_empty,
    output logic                             out_full
);
    import bse_pkg::*;

    // entry memory and its registered read port
    logic [DW-1:0] store_mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] cap_reg;
    cmd_code_t     cmd_reg, cmd_next;
    logic [DW-1:0] key_reg, key_next;
    status_code_t  status_reg, status_next;
    logic [AW-1:0] where_reg, where_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic          m_valid_reg;
    status_code_t  o_status_reg;
    logic [DW-1:0] o_data_reg;
    logic [AW-1:0] o_where_reg;
    logic [FW-1:0] o_fill_reg;
    logic          o_empty_reg;
    logic          o_full_reg;

    logic [FW-1:0] cap_eff;
    logic          is_full;
    logic [FW-1:0] fill_dec;
    logic [FW-1:0] idx_inc;
    logic          pos_bad;
    logic          hit;
    logic          last;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] res_data;

    // effective capacity, clamped to 1..DEPTH
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = FW'(1);
        end else if (cap_reg > FW'(DEPTH)) begin
            cap_eff = FW'(DEPTH);
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign is_full  = (fill_reg >= cap_eff);
    assign fill_dec = fill_reg - FW'(1);
    assign idx_inc  = {1'b0, idx_reg} + FW'(1);
    assign pos_bad  = ({1'b0, in_position} >= fill_reg);
    assign hit      = (rdata_reg == key_reg);
    assign last     = (idx_inc >= fill_reg);

    // status toward the controller
    assign stat.scan_needed = (in_cmd == CMD_SEARCH) && (fill_reg != '0);
    assign stat.scan_done   = hit || last;
    assign stat.out_free    = !m_valid_reg || m_tready;

    // command decode at item accept and search walk steps
    always_comb begin
        fill_next   = fill_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        status_next = status_reg;
        where_next  = where_reg;
        idx_next    = idx_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = in_position;
        rd_addr     = in_position;
        if (cmd.take_item) begin
            cmd_next    = in_cmd;
            key_next    = in_value;
            status_next = ST_OK;
            where_next  = '0;
            idx_next    = '0;
            unique case (in_cmd)
                CMD_PUSH: begin
                    if (is_full) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[AW-1:0];
                        fill_next = fill_reg + FW'(1);
                    end
                end
                CMD_POP: begin
                    if (fill_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = fill_dec[AW-1:0];
                        where_next = fill_dec[AW-1:0];
                        fill_next  = fill_dec;
                    end
                end
                CMD_PEEK: begin
                    if (pos_bad) begin
                        status_next = ST_RANGE;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
                CMD_CHANGE: begin
                    if (pos_bad) begin
                        status_next = ST_RANGE;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
                CMD_SEARCH: begin
                    status_next = ST_NOTFOUND;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                end
                default: ;
            endcase
        end else if (cmd.scan_step) begin
            if (hit) begin
                status_next = ST_OK;
                where_next  = idx_reg;
            end else if (!last) begin
                rd_en    = 1'b1;
                rd_addr  = idx_inc[AW-1:0];
                idx_next = idx_inc[AW-1:0];
            end
        end
    end

    // entry memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= in_value;
        end
        if (rd_en) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            cap_reg  <= CAP_RESET;
        end else begin
            fill_reg <= fill_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        where_reg  <= where_next;
        idx_reg    <= idx_next;
    end

    // word returned only by a successful pop or peek
    assign res_data = (((cmd_reg == CMD_POP) || (cmd_reg == CMD_PEEK)) && (status_reg == ST_OK))
                      ? rdata_reg : '0;

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            o_status_reg <= status_reg;
            o_data_reg   <= res_data;
            o_where_reg  <= where_reg;
            o_fill_reg   <= fill_reg;
            o_empty_reg  <= (fill_reg == '0);
            o_full_reg   <= is_full;
        end
    end

    assign m_valid    = m_valid_reg;
    assign out_status = o_status_reg;
    assign out_data   = o_data_reg;
    assign out_where  = o_where_reg;
    assign out_fill   = o_fill_reg;
    assign out_empty  = o_empty_reg;
    assign out_full   = o_full_reg;

endmodule

FILE: rtl/bounded_stack_engine.sv
// bounded_stack_engine: bounded lifo stack of 32-bit words, one result per item
// push, pop, peek, change and unused codes pass from the idle state to the emit state;
// a nonempty search scans in between, comparing 1..fill entries, one memory read per cycle
// one item at a time: the next is taken once the last result is in the output register;
// a result held by the receiver keeps the sequencer in emit and the input closed
// reset (aresetn low, synchronous): fill cleared, capacity 16, no result pending;
// the entry memory is not cleared
`timescale 1ns / 1ps

module bounded_stack_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[35:32], zero[39:36]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // data_out[31:0], where_index[35:32], fill_count[40:36],
                                   // is_empty[41], is_full[42], zero[47:43]
    output logic [2:0]  m_tuser,   // status[2:0]
    // capacity register
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);
    import bse_pkg::*;

    ctrl_cmd_t           cmd;
    dp_stat_t            stat;
    status_code_t        out_status;
    logic signed [DW-1:0] out_data;
    logic [AW-1:0]       out_where;
    logic [FW-1:0]       out_fill;
    logic                out_empty;
    logic                out_full;

    // sequencer
    bse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and result path
    bse_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_cmd      (s_tuser),
        .in_value    (s_tdata[31:0]),
        .in_position (s_tdata[35:32]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .m_tready    (m_tready),
        .m_valid     (m_tvalid),
        .out_status  (out_status),
        .out_data    (out_data),
        .out_where   (out_where),
        .out_fill    (out_fill),
        .out_empty   (out_empty),
        .out_full    (out_full)
    );

    // result packing
    assign m_tdata = {5'b0, out_full, out_empty, out_fill, out_where, out_data};
    assign m_tuser = out_status;

    // no second item is taken right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous one in progress");

    // a result never appears in the cycle right after its accept
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !(m_tvalid && !m_tready)) |=> !$rose(m_tvalid))
        else $error("result produced too early");

    // reported fill stays in range and agrees with the empty flag
    a_fill_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_fill <= FW'(DEPTH)) && (out_empty == (out_fill == '0))))
        else $error("fill count and empty flag disagree");

endmodule
